@@ rtl/sab_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_pkg
// shared types and constants for the suffix automaton builder
// ----------------------------------------------------------------------------
package sab_pkg;
  localparam int MaxLen   = 1024;
  localparam int Alphabet = 26;
  localparam int NStates  = 2 * MaxLen;
  localparam int SW       = $clog2(NStates);          // state index width
  localparam int TW       = SW + 1;                   // transition entry width
  localparam int AW       = $clog2(Alphabet);         // letter width
  localparam int MW       = $clog2(NStates * 32);     // transition memory address
  localparam int LW       = $clog2(MaxLen + 1);       // letter count width
  localparam logic [TW-1:0] NoEdge = TW'(NStates);

  typedef enum logic [1:0] {
    ST_EXTENDED = 2'd0,
    ST_CLONED   = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_LEN_RD, S_LEN_WR, S_ROW_CLR,
    S_WALK_RD, S_WALK_CHK, S_Q_RD, S_Q_CHK,
    S_CP_RD, S_CP_WR, S_CP_LAST, S_RED_RD, S_RED_CHK, S_FINISH
  } fsm_t;

  // transition address: state row times 32 plus letter
  function automatic logic [MW-1:0] tr_addr(input logic [SW-1:0] s,
                                            input logic [AW-1:0] a);
    tr_addr = {s, a};
  endfunction
endpackage

@@ rtl/suffix_automaton_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_builder
// online suffix automaton construction, one letter per transaction
// ----------------------------------------------------------------------------
// sequence: after accept the new row is cleared and the link path is walked;
//   when the walk stops on an edge its target is read, and when a clone is
//   made the target's row is copied and the edges to it are redirected
// a restart first clears the root row; rejects skip the work and go to the
//   finish step (after the root row clear when a restart comes with them)
// throughput: one transaction at a time, busy until out_valid is pulsed
// the transition memory port (one read, one write per cycle) sets the pace
// reset: synchronous active-low rst_n, then a clear of the root row
//   during which busy is high; the receiver cannot stall results
module suffix_automaton_builder import sab_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [4:0]    in_symbol,
  input  logic          in_new_string,
  output logic          out_valid,
  output logic [10:0]   out_new_state,
  output logic [10:0]   out_new_link,
  output logic [10:0]   out_clone_state,
  output logic [11:0]   out_state_total,
  output logic [10:0]   out_text_length,
  output logic [1:0]    out_status
);
  fsm_t state_r, state_nxt;

  logic [AW-1:0] sym_r, sym_nxt;
  logic [SW:0]   cnt_r, cnt_nxt;      // state_count
  logic [SW-1:0] last_r, last_nxt;
  logic [LW-1:0] seen_r, seen_nxt;
  logic [SW-1:0] cur_r, cur_nxt, p_r, p_nxt, q_r, q_nxt, cl_r, cl_nxt;
  logic [SW-1:0] plen_r, plen_nxt, lnk_r, lnk_nxt;
  logic [AW-1:0] idx_r, idx_nxt;      // shared row sweep counter
  logic          cloned_r, cloned_nxt;
  logic          ov_r, ov_nxt;
  status_t       ost_r, ost_nxt;

  // memory ports
  logic          t_we;
  logic [MW-1:0] t_waddr, t_raddr;
  logic [TW-1:0] t_wdata, t_rdata;
  logic          l_we, k_we;
  logic [SW-1:0] l_waddr, l_wdata, l_raddr, l_rdata;
  logic [SW-1:0] k_waddr, k_wdata, k_raddr, k_rdata;

  sab_trans_mem u_tr (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  sab_node_mem u_node (
    .clk(clk),
    .len_we(l_we), .len_waddr(l_waddr), .len_wdata(l_wdata),
    .len_raddr(l_raddr), .len_rdata(l_rdata),
    .lnk_we(k_we), .lnk_waddr(k_waddr), .lnk_wdata(k_wdata),
    .lnk_raddr(k_raddr), .lnk_rdata(k_rdata)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= (SW+1)'(1);
      last_r  <= '0;
      seen_r  <= '0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
      ost_r   <= ST_EXTENDED;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      seen_r  <= seen_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
      ost_r   <= ost_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sym_r    <= sym_nxt;
    cur_r    <= cur_nxt;
    p_r      <= p_nxt;
    q_r      <= q_nxt;
    cl_r     <= cl_nxt;
    plen_r   <= plen_nxt;
    lnk_r    <= lnk_nxt;
    cloned_r <= cloned_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    sym_nxt    = sym_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    seen_nxt   = seen_r;
    cur_nxt    = cur_r;
    p_nxt      = p_r;
    q_nxt      = q_r;
    cl_nxt     = cl_r;
    plen_nxt   = plen_r;
    lnk_nxt    = lnk_r;
    idx_nxt    = idx_r;
    cloned_nxt = cloned_r;
    ov_nxt     = 1'b0;
    ost_nxt    = ost_r;
    t_we = 1'b0; t_waddr = '0; t_wdata = NoEdge; t_raddr = '0;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
    k_we = 1'b0; k_waddr = '0; k_wdata = '0; k_raddr = '0;

    unique case (state_r)
      // clear the root row after reset or restart
      S_INIT: begin
        t_we = 1'b1; t_waddr = tr_addr('0, idx_r); t_wdata = NoEdge;
        l_we = 1'b1; l_waddr = '0; l_wdata = '0;
        if (idx_r == AW'(Alphabet - 1)) begin
          idx_nxt = '0;
          // pending letter after a restart: cur_r/ost_r flag it
          if (cur_r == '0 && ost_r == ST_CLONED) begin
            ost_nxt   = ST_EXTENDED;
            state_nxt = S_LEN_RD;
          end else if (ost_r == ST_REJECTED) begin
            // restart that came with a rejected letter still reports
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          sym_nxt    = in_symbol[AW-1:0];
          cloned_nxt = 1'b0;
          cl_nxt     = '0;
          if (in_new_string) begin
            cnt_nxt  = (SW+1)'(1);
            last_nxt = '0;
            seen_nxt = '0;
          end
          if (in_symbol >= 5'(Alphabet) ||
              (!in_new_string && seen_r >= LW'(MaxLen))) begin
            ost_nxt = ST_REJECTED;
            if (in_new_string) begin
              cur_nxt   = '1;
              state_nxt = S_INIT;
            end else begin
              state_nxt = S_FINISH;
            end
          end else if (in_new_string) begin
            cur_nxt   = '0;
            ost_nxt   = ST_CLONED;  // marks a letter pending after the clear
            state_nxt = S_INIT;
          end else begin
            ost_nxt   = ST_EXTENDED;
            state_nxt = S_LEN_RD;
          end
        end
      end
      S_LEN_RD: begin
        if (ost_r == ST_REJECTED) begin
          state_nxt = S_FINISH;
        end else begin
          l_raddr   = last_r;
          cur_nxt   = cnt_r[SW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          p_nxt     = last_r;
          state_nxt = S_LEN_WR;
        end
      end
      S_LEN_WR: begin
        l_we = 1'b1; l_waddr = cur_r; l_wdata = l_rdata + 1'b1;
        idx_nxt   = '0;
        state_nxt = S_ROW_CLR;
      end
      S_ROW_CLR: begin
        t_we = 1'b1; t_waddr = tr_addr(cur_r, idx_r); t_wdata = NoEdge;
        if (idx_r == AW'(Alphabet - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_WALK_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_WALK_RD: begin
        t_raddr = tr_addr(p_r, sym_r);
        k_raddr = p_r;
        l_raddr = p_r;
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (t_rdata == NoEdge) begin
          t_we = 1'b1; t_waddr = tr_addr(p_r, sym_r); t_wdata = TW'(cur_r);
          if (p_r == '0) begin
            lnk_nxt   = '0;
            state_nxt = S_FINISH;
          end else begin
            p_nxt     = k_rdata;
            state_nxt = S_WALK_RD;
          end
        end else begin
          q_nxt     = t_rdata[SW-1:0];
          plen_nxt  = l_rdata;
          state_nxt = S_Q_RD;
        end
      end
      S_Q_RD: begin
        l_raddr   = q_r;
        k_raddr   = q_r;
        state_nxt = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (plen_r + 1'b1 == l_rdata) begin
          lnk_nxt   = q_r;
          state_nxt = S_FINISH;
        end else begin
          cl_nxt     = cnt_r[SW-1:0];
          cnt_nxt    = cnt_r + 1'b1;
          cloned_nxt = 1'b1;
          lnk_nxt    = cnt_r[SW-1:0];
          l_we = 1'b1; l_waddr = cnt_r[SW-1:0]; l_wdata = plen_r + 1'b1;
          k_we = 1'b1; k_waddr = cnt_r[SW-1:0]; k_wdata = k_rdata;
          idx_nxt   = '0;
          state_nxt = S_CP_RD;
        end
      end
      // copy q's row into the clone, one read then one write per letter
      S_CP_RD: begin
        t_raddr   = tr_addr(q_r, idx_r);
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        t_we = 1'b1; t_waddr = tr_addr(cl_r, idx_r); t_wdata = t_rdata;
        if (idx_r == AW'(Alphabet - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_CP_LAST;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_CP_RD;
        end
      end
      S_CP_LAST: begin
        k_we = 1'b1; k_waddr = q_r; k_wdata = cl_r;
        state_nxt = S_RED_RD;
      end
      S_RED_RD: begin
        t_raddr   = tr_addr(p_r, sym_r);
        k_raddr   = p_r;
        state_nxt = S_RED_CHK;
      end
      S_RED_CHK: begin
        if (t_rdata == TW'(q_r)) begin
          t_we = 1'b1; t_waddr = tr_addr(p_r, sym_r); t_wdata = TW'(cl_r);
          if (p_r == '0) begin
            state_nxt = S_FINISH;
          end else begin
            p_nxt     = k_rdata;
            state_nxt = S_RED_RD;
          end
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
        if (ost_r != ST_REJECTED) begin
          k_we = 1'b1; k_waddr = cur_r; k_wdata = lnk_r;
          last_nxt = cur_r;
          seen_nxt = seen_r + 1'b1;
          ost_nxt  = cloned_r ? ST_CLONED : ST_EXTENDED;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result is registered at the finish step and shown in the cycle after it
  logic [SW-1:0] o_state_r, o_link_r, o_clone_r;
  always_ff @(posedge clk) begin
    if (state_r == S_FINISH) begin
      o_state_r <= (ost_r == ST_REJECTED) ? '0 : cur_r;
      o_link_r  <= (ost_r == ST_REJECTED) ? '0 : lnk_r;
      o_clone_r <= (ost_r == ST_REJECTED) ? '0 : cl_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_new_state   = o_state_r;
  assign out_new_link    = o_link_r;
  assign out_clone_state = o_clone_r;
  assign out_state_total = cnt_r;
  assign out_text_length = seen_r;
  assign out_status      = ost_r;

`ifndef SYNTH
  // a result only follows the finish step
  a_valid_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_FINISH) else $error("stray result");
  // no transaction taken while working
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> busy) else $error("busy low while working");
  // letter count never passes the text limit
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= LW'(MaxLen)) else $error("text length overflow");
  // an extended result leaves at least two states
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EXTENDED |-> out_state_total >= 12'd2)
    else $error("state total too small");
`endif
endmodule

@@ rtl/sab_trans_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_trans_mem
// transition store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sab_trans_mem import sab_pkg::*; (
  input  logic          clk,
  input  logic          we,
  input  logic [MW-1:0] waddr,
  input  logic [TW-1:0] wdata,
  input  logic [MW-1:0] raddr,
  output logic [TW-1:0] rdata
);
  logic [TW-1:0] mem [NStates*32];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/sab_node_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_node_mem
// per-state longest length and suffix link store
// ----------------------------------------------------------------------------
module sab_node_mem import sab_pkg::*; (
  input  logic          clk,
  input  logic          len_we,
  input  logic [SW-1:0] len_waddr,
  input  logic [SW-1:0] len_wdata,
  input  logic [SW-1:0] len_raddr,
  output logic [SW-1:0] len_rdata,
  input  logic          lnk_we,
  input  logic [SW-1:0] lnk_waddr,
  input  logic [SW-1:0] lnk_wdata,
  input  logic [SW-1:0] lnk_raddr,
  output logic [SW-1:0] lnk_rdata
);
  logic [SW-1:0] len_mem [NStates];
  logic [SW-1:0] lnk_mem [NStates];

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_rdata <= len_mem[len_raddr];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) lnk_mem[lnk_waddr] <= lnk_wdata;
    lnk_rdata <= lnk_mem[lnk_raddr];
  end
endmodule

@@ verif/tb_suffix_automaton_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_suffix_automaton_builder
// self-checking bench: letters are sent through the start/busy handshake, a
// behavioral copy of the automaton predicts every result, and a checker
// compares each out_valid strobe field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb_suffix_automaton_builder;
  import sab_pkg::*;

  localparam int WatchLimit = 20000;   // quiet cycles before giving up
  localparam int TailCycles = 200;

  typedef struct {
    logic [10:0] new_state;
    logic [10:0] new_link;
    logic [10:0] clone_state;
    logic [11:0] state_total;
    logic [10:0] text_length;
    status_t     status;
  } step_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [4:0]  in_symbol = '0;
  logic        in_new_string = 1'b0;
  logic        out_valid;
  logic [10:0] out_new_state, out_new_link, out_clone_state, out_text_length;
  logic [11:0] out_state_total;
  logic [1:0]  out_status;

  suffix_automaton_builder uut (
    .clk, .rst_n, .start, .busy, .in_symbol, .in_new_string, .out_valid,
    .out_new_state, .out_new_link, .out_clone_state, .out_state_total,
    .out_text_length, .out_status
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // automaton mirror
  int sa_len [NStates];
  int sa_link[NStates];
  int sa_edge[NStates * Alphabet];
  int sa_count, sa_last, sa_letters;

  step_res_t pending[$];
  int  n_sent, n_clones, n_rejects, n_errors;
  bit  no_idle;
  int  quiet;

  function automatic void sa_restart();
    for (int i = 0; i < Alphabet; i++) sa_edge[i] = NStates;
    sa_len[0] = 0;
    sa_link[0] = 0;
    sa_count = 1;
    sa_last = 0;
    sa_letters = 0;
  endfunction

  // extend the mirror by one letter and return the expected result
  function automatic step_res_t sa_extend(int sym, bit restart);
    step_res_t r;
    int cur, p, q, cl, lnk;
    bit walking, cloned;
    cl = 0;
    cloned = 1'b0;
    if (restart) sa_restart();
    if (sym >= Alphabet || sa_letters >= MaxLen || sa_count + 2 > NStates) begin
      r.new_state = '0;
      r.new_link = '0;
      r.clone_state = '0;
      r.state_total = 12'(sa_count);
      r.text_length = 11'(sa_letters);
      r.status = ST_REJECTED;
      return r;
    end
    cur = sa_count++;
    sa_len[cur] = sa_len[sa_last] + 1;
    for (int i = 0; i < Alphabet; i++) sa_edge[cur*Alphabet+i] = NStates;
    p = sa_last;
    walking = 1'b1;
    // give every state on the link path without this letter an edge to cur
    while (walking && sa_edge[p*Alphabet+sym] == NStates) begin
      sa_edge[p*Alphabet+sym] = cur;
      if (p == 0) walking = 1'b0;
      else p = sa_link[p];
    end
    if (!walking) begin
      lnk = 0;
    end else begin
      q = sa_edge[p*Alphabet+sym] % NStates;
      if (sa_len[p] + 1 == sa_len[q]) begin
        lnk = q;
      end else begin
        // split q: the clone takes q's row and link, edges to q are redirected
        cl = sa_count++;
        cloned = 1'b1;
        sa_len[cl] = sa_len[p] + 1;
        for (int i = 0; i < Alphabet; i++)
          sa_edge[cl*Alphabet+i] = sa_edge[q*Alphabet+i];
        sa_link[cl] = sa_link[q];
        while (walking && sa_edge[p*Alphabet+sym] == q) begin
          sa_edge[p*Alphabet+sym] = cl;
          if (p == 0) walking = 1'b0;
          else p = sa_link[p];
        end
        sa_link[q] = cl;
        lnk = cl;
      end
    end
    sa_link[cur] = lnk;
    sa_last = cur;
    sa_letters++;
    r.new_state = 11'(cur);
    r.new_link = 11'(lnk);
    r.clone_state = 11'(cl);
    r.state_total = 12'(sa_count);
    r.text_length = 11'(sa_letters);
    r.status = cloned ? ST_CLONED : ST_EXTENDED;
    return r;
  endfunction

  // mostly short gaps, a few long ones, none at all in burst stretches
  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // send one letter transaction and record its predicted result
  task automatic send_letter(int sym, bit restart);
    step_res_t r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_symbol <= 5'(sym);
    in_new_string <= restart;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = sa_extend(sym, restart);
    pending.insert(pending.size(), r);
    n_sent++;
    if (r.status == ST_CLONED) n_clones++;
    if (r.status == ST_REJECTED) n_rejects++;
  endtask

  // sender holds off until every expected result has come back
  task automatic drain();
    @(posedge clk);
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  // result checker, sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin
    step_res_t e;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        $error("unexpected result transaction, state %0d", out_new_state);
        n_errors++;
      end else begin
        e = pending.pop_front();
        if (out_new_state !== e.new_state) begin
          $error("new_state exp %0d got %0d", e.new_state, out_new_state);
          n_errors++;
        end
        if (out_new_link !== e.new_link) begin
          $error("new_link exp %0d got %0d", e.new_link, out_new_link);
          n_errors++;
        end
        if (out_clone_state !== e.clone_state) begin
          $error("clone_state exp %0d got %0d", e.clone_state, out_clone_state);
          n_errors++;
        end
        if (out_state_total !== e.state_total) begin
          $error("state_total exp %0d got %0d", e.state_total, out_state_total);
          n_errors++;
        end
        if (out_text_length !== e.text_length) begin
          $error("text_length exp %0d got %0d", e.text_length, out_text_length);
          n_errors++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // restarts, growth, clones, the last letter and out-of-range letters
  task automatic test_directed();
    send_letter(0, 1'b1);
    send_letter(0, 1'b0);
    send_letter(1, 1'b0);
    send_letter(1, 1'b0);            // splits a state
    send_letter(0, 1'b0);
    send_letter(1, 1'b0);
    send_letter(25, 1'b0);
    send_letter(26, 1'b0);           // rejected, nothing changes
    send_letter(0, 1'b0);
    send_letter(31, 1'b1);           // restart still happens, letter rejected
    send_letter(25, 1'b0);
    send_letter(25, 1'b0);
    send_letter(17, 1'b0);
    send_letter(25, 1'b0);
    send_letter(30, 1'b0);
    send_letter(5, 1'b1);
    send_letter(10, 1'b0);
    send_letter(5, 1'b0);
    send_letter(10, 1'b0);
    send_letter(10, 1'b0);
    drain();
  endtask

  // one text that runs into the letter limit, then rejects, then a restart
  task automatic test_full_store();
    int span;
    span = $urandom_range(2, 4);
    send_letter($urandom_range(0, span - 1), 1'b1);
    for (int i = 0; i < MaxLen + 4; i++) begin
      if (i % 200 == 0) no_idle = $urandom_range(0, 1);
      send_letter($urandom_range(0, span - 1), 1'b0);
    end
    send_letter($urandom_range(0, 31), 1'b0);
    no_idle = 1'b0;
    send_letter($urandom_range(0, 25), 1'b1);
    drain();
  endtask

  // words of random length over random small alphabets, some noise
  task automatic test_random_words(int count);
    int span, wlen, sym;
    int sent;
    sent = 0;
    while (sent < count) begin
      span = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 26) : $urandom_range(2, 4);
      wlen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      no_idle = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < wlen; i++) begin
        sym = ($urandom_range(0, 40) == 0) ? $urandom_range(26, 31)
                                           : $urandom_range(0, span - 1);
        send_letter(sym, i == 0 ? 1'b1 : ($urandom_range(0, 60) == 0));
        sent++;
      end
      if (sent > count / 2 && sent - wlen <= count / 2) drain();
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    n_sent = 0;
    n_clones = 0;
    n_rejects = 0;
    n_errors = 0;
    no_idle = 1'b0;
    quiet = 0;
    sa_restart();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_store();
    test_random_words(700);
    $display("covered %0d letters: %0d with a clone, %0d rejected", n_sent,
             n_clones, n_rejects);
    $display("includes restarts, out-of-range letters and a filled store");
    if (n_errors == 0 && pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/sab_pkg.sv
rtl/sab_trans_mem.sv
rtl/sab_node_mem.sv
rtl/suffix_automaton_builder.sv
verif/tb_suffix_automaton_builder.sv
